### rtl/msps_pkg.sv
// Shared types, constants and the coil table for the multi stepper phase sequencer.
// Used by msps_ctrl, msps_datapath and the top level; no dependencies.
`default_nettype none

package msps_pkg;

   localparam int MAX_MOTORS   = 8;
   localparam int ID_W         = 3;
   localparam int COUNT_W      = 4;
   localparam int TIME_W       = 32;
   localparam int INTERVAL_W   = 16;
   localparam int WORD_W       = 32;
   localparam int PHASE_W      = 2;
   localparam int COIL_W       = 4;
   localparam int OP_W         = 2;

   localparam int REQ_TDATA_W  = 88;  // id, now, interval, value = 83 bits
   localparam int RSP_TDATA_W  = 72;  // stepped, coils, done, position, remaining = 70 bits

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // register index of the motor count within the register map
   localparam logic REG_MOTORS_IN_USE = 1'b0;

   localparam logic [OP_W-1:0] OP_MOVE      = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_STEPS = 2'd1;
   localparam logic [OP_W-1:0] OP_SET_POS   = 2'd2;
   localparam logic [OP_W-1:0] OP_RESET     = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

   typedef struct packed {
      logic capture;   // latch the accepted request
      logic execute;   // update motor state and load the result register
   } msps_cmd_type;

   function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] coils;
      unique case (phase)
         2'd0:    coils = 4'b1001;
         2'd1:    coils = 4'b0101;
         2'd2:    coils = 4'b0110;
         default: coils = 4'b1010;
      endcase
      return coils;
   endfunction

endpackage

`default_nettype wire

### rtl/msps_ctrl.sv
// Controller for the phase sequencer: accept, execute and result-valid handling.
// Depends on msps_pkg for the command struct.
`default_nettype none

module msps_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output msps_pkg::msps_cmd_type     cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic stall;

   // the result register is busy while an earlier result is still unclaimed
   assign stall = rsp_valid_ff & ~rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = stall;
      req_tready   = 1'b0;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         default: begin
            if (!stall) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted request did not move to execute");

   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !stall) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("execute did not produce a result");

   a_exec_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && stall) |=> (state_ff == S_EXEC && rsp_valid_ff))
      else $error("execute overran a pending result");

   a_no_accept_in_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> !req_tready)
      else $error("request accepted while executing");

endmodule

`default_nettype wire

### rtl/msps_datapath.sv
// Datapath of the phase sequencer: request latch, per-motor state and result register.
// Depends on msps_pkg for widths, operation codes, coil table and command struct.
`default_nettype none

module msps_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire msps_pkg::msps_cmd_type                cmd,
   input  wire logic [msps_pkg::COUNT_W-1:0]          motors_in_use,
   input  wire logic [msps_pkg::OP_W-1:0]             req_operation,
   input  wire logic [msps_pkg::ID_W-1:0]             req_motor_id,
   input  wire logic [msps_pkg::TIME_W-1:0]           req_now_time,
   input  wire logic [msps_pkg::INTERVAL_W-1:0]       req_step_interval,
   input  wire logic [msps_pkg::WORD_W-1:0]           req_value,
   output logic                                       rsp_bad_id,
   output logic                                       rsp_stepped,
   output logic [msps_pkg::COIL_W-1:0]                rsp_coil_pattern,
   output logic                                       rsp_done_res,
   output logic [msps_pkg::WORD_W-1:0]                rsp_position,
   output logic [msps_pkg::WORD_W-1:0]                rsp_steps_remaining
);

   // latched request
   logic [msps_pkg::OP_W-1:0]       op_ff;
   logic [msps_pkg::ID_W-1:0]       id_ff;
   logic [msps_pkg::TIME_W-1:0]     now_ff;
   logic [msps_pkg::INTERVAL_W-1:0] interval_ff;
   logic [msps_pkg::WORD_W-1:0]     value_ff;

   // per-motor state
   logic [msps_pkg::PHASE_W-1:0] phase_ff  [msps_pkg::MAX_MOTORS];
   logic [msps_pkg::TIME_W-1:0]  next_ff   [msps_pkg::MAX_MOTORS];
   logic [msps_pkg::WORD_W-1:0]  remain_ff [msps_pkg::MAX_MOTORS];
   logic [msps_pkg::WORD_W-1:0]  pos_ff    [msps_pkg::MAX_MOTORS];

   // result register
   logic                         bad_ff, stepped_ff, done_ff;
   logic [msps_pkg::COIL_W-1:0]  coil_ff;
   logic [msps_pkg::WORD_W-1:0]  rpos_ff, rrem_ff;

   logic [msps_pkg::COUNT_W-1:0] eff_count;
   logic                         bad;
   logic [msps_pkg::PHASE_W-1:0] phase_cur, phase_in;
   logic [msps_pkg::TIME_W-1:0]  next_cur, next_in;
   logic [msps_pkg::WORD_W-1:0]  remain_cur, remain_in;
   logic [msps_pkg::WORD_W-1:0]  pos_cur, pos_in;
   logic                         do_step;

   // zero acts as one, anything past MAX_MOTORS saturates to MAX_MOTORS
   always_comb begin
      priority if (motors_in_use == '0)
         eff_count = msps_pkg::COUNT_W'(1);
      else if (motors_in_use > msps_pkg::COUNT_W'(msps_pkg::MAX_MOTORS))
         eff_count = msps_pkg::COUNT_W'(msps_pkg::MAX_MOTORS);
      else
         eff_count = motors_in_use;
   end

   assign bad = {1'b0, id_ff} >= eff_count;

   assign phase_cur  = phase_ff[id_ff];
   assign next_cur   = next_ff[id_ff];
   assign remain_cur = remain_ff[id_ff];
   assign pos_cur    = pos_ff[id_ff];

   assign do_step = (op_ff == msps_pkg::OP_MOVE) && (remain_cur != '0) && (now_ff > next_cur);

   always_comb begin
      phase_in  = phase_cur;
      next_in   = next_cur;
      remain_in = remain_cur;
      pos_in    = pos_cur;
      unique case (op_ff)
         msps_pkg::OP_MOVE: begin
            if (do_step) begin
               next_in = now_ff + msps_pkg::TIME_W'(interval_ff);
               // negative remaining counts up toward zero, phase runs backward
               if (remain_cur[msps_pkg::WORD_W-1]) begin
                  phase_in  = phase_cur - msps_pkg::PHASE_W'(1);
                  remain_in = remain_cur + msps_pkg::WORD_W'(1);
                  pos_in    = pos_cur + msps_pkg::WORD_W'(1);
               end else begin
                  phase_in  = phase_cur + msps_pkg::PHASE_W'(1);
                  remain_in = remain_cur - msps_pkg::WORD_W'(1);
                  pos_in    = pos_cur - msps_pkg::WORD_W'(1);
               end
            end
         end
         msps_pkg::OP_SET_STEPS: remain_in = value_ff;
         msps_pkg::OP_SET_POS:   pos_in    = value_ff;
         default: begin
            phase_in  = '0;
            next_in   = now_ff;
            remain_in = '0;
            pos_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         id_ff       <= req_motor_id;
         now_ff      <= req_now_time;
         interval_ff <= req_step_interval;
         value_ff    <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < msps_pkg::MAX_MOTORS; i++) begin
            phase_ff[i]  <= '0;
            next_ff[i]   <= '0;
            remain_ff[i] <= '0;
            pos_ff[i]    <= '0;
         end
      end else if (cmd.execute && !bad) begin
         phase_ff[id_ff]  <= phase_in;
         next_ff[id_ff]   <= next_in;
         remain_ff[id_ff] <= remain_in;
         pos_ff[id_ff]    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         bad_ff     <= bad;
         stepped_ff <= !bad && do_step;
         coil_ff    <= (!bad && do_step) ? msps_pkg::coil_of(phase_cur) : '0;
         done_ff    <= !bad && (remain_in == '0);
         rpos_ff    <= bad ? '0 : pos_in;
         rrem_ff    <= bad ? '0 : remain_in;
      end
   end

   assign rsp_bad_id          = bad_ff;
   assign rsp_stepped         = stepped_ff;
   assign rsp_coil_pattern    = coil_ff;
   assign rsp_done_res        = done_ff;
   assign rsp_position        = rpos_ff;
   assign rsp_steps_remaining = rrem_ff;

   a_bad_result_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && bad) |=> (bad_ff && !stepped_ff && coil_ff == '0 && rrem_ff == '0))
      else $error("rejected id produced a nonzero result");

   a_step_has_coils: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (stepped_ff == (coil_ff != '0)))
      else $error("coil pattern disagrees with step flag");

   a_bad_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && bad) |=> $stable(remain_ff[0]) && $stable(pos_ff[0]))
      else $error("rejected id changed motor state");

endmodule

`default_nettype wire

### rtl/multi_stepper_phase_sequencer.sv
// An accepted request enters execute, which loads the result register and sets result valid.
// No request is accepted until the held one executes; execute waits for an untaken result.
// The single request latch and the result register set this limit.
// Reset (synchronous, active high) clears all motor state to zero at once, sets the
// motor count to one and clears result valid; no clearing pass follows.
// Top level: stream ports, configuration register, controller and datapath; uses msps_pkg.
`default_nettype none

module multi_stepper_phase_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [2:0] motor_id, [34:3] now_time, [50:35] step_interval, [82:51] value, zero fill
   input  wire logic [msps_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] operation
   input  wire logic [msps_pkg::OP_W-1:0]           req_tuser,
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] stepped, [4:1] coil_pattern, [5] done_res, [37:6] position,
   // [69:38] steps_remaining, zero fill
   output logic [msps_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   // [0] bad_id
   output logic                                     rsp_tuser,
   // configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [msps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [msps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [msps_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   msps_pkg::msps_cmd_type cmd;

   logic [msps_pkg::COUNT_W-1:0] motors_ff, motors_in;
   logic                         csr_write;
   logic                         reg_hit;

   logic                         bad_id, stepped, done_res;
   logic [msps_pkg::COIL_W-1:0]  coil_pattern;
   logic [msps_pkg::WORD_W-1:0]  position, steps_remaining;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[2] == msps_pkg::REG_MOTORS_IN_USE);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign motors_in  = (csr_write && reg_hit) ? csr_pwdata[msps_pkg::COUNT_W-1:0] : motors_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         motors_ff <= msps_pkg::COUNT_RESET;
      end else begin
         motors_ff <= motors_in;
      end
   end

   assign csr_prdata = reg_hit ? msps_pkg::CSR_DATA_W'(motors_ff) : '0;

   msps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   msps_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .motors_in_use       (motors_ff),
      .req_operation       (req_tuser),
      .req_motor_id        (req_tdata[2:0]),
      .req_now_time        (req_tdata[34:3]),
      .req_step_interval   (req_tdata[50:35]),
      .req_value           (req_tdata[82:51]),
      .rsp_bad_id          (bad_id),
      .rsp_stepped         (stepped),
      .rsp_coil_pattern    (coil_pattern),
      .rsp_done_res        (done_res),
      .rsp_position        (position),
      .rsp_steps_remaining (steps_remaining)
   );

   // upper result bits are fill and carry nothing
   assign rsp_tdata = {2'b00, steps_remaining, position, done_res, coil_pattern, stepped};
   assign rsp_tuser = bad_id;

endmodule

`default_nettype wire
